// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/lwfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lwfs_pkg
// Shared types and constants of the display window fill sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lwfs_pkg;

  // Display bus command codes
  localparam logic [7:0] CMD_COLUMN_ADDR  = 8'd42;
  localparam logic [7:0] CMD_PAGE_ADDR    = 8'd43;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'd44;

  // Repeat count width and its saturation value
  localparam int unsigned        COUNT_W   = 19;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Configuration port
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned SCR_W   = 10;
  localparam logic        REG_SCREEN_WIDTH  = 1'b0;
  localparam logic        REG_SCREEN_HEIGHT = 1'b1;

  // Fill request word
  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] fill_color;
  } req_t;

  // Bus word
  typedef struct packed {
    logic               is_data;
    logic [15:0]        bus_word;
    logic [COUNT_W-1:0] repeat_count;
    logic               last_word;
  } res_t;

  // Screen size registers
  typedef struct packed {
    logic [SCR_W-1:0] screen_width;
    logic [SCR_W-1:0] screen_height;
  } cfg_t;

  // Clipped window, corners inclusive
  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [15:0] color;
  } win_t;

  // Position within the twelve-word sequence
  typedef enum logic [3:0] {
    WS_CMD_COL  = 4'd0,
    WS_XS_HI    = 4'd1,
    WS_XS_LO    = 4'd2,
    WS_XE_HI    = 4'd3,
    WS_XE_LO    = 4'd4,
    WS_CMD_PAGE = 4'd5,
    WS_YS_HI    = 4'd6,
    WS_YS_LO    = 4'd7,
    WS_YE_HI    = 4'd8,
    WS_YE_LO    = 4'd9,
    WS_CMD_MEMW = 4'd10,
    WS_PIXELS   = 4'd11
  } word_sel_e;

endpackage

`default_nettype wire

// ===== rtl/lwfs_apb_regs.sv =====
// ----------------------------------------------------------------------------
// lwfs_apb_regs
// APB register file holding the visible screen width and height.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lwfs_apb_regs
  import lwfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready,
  output      cfg_t              cfg_o
);

  logic [SCR_W-1:0] width_q, width_d;
  logic [SCR_W-1:0] height_q, height_d;
  logic             wr_en;
  logic             reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  // Register write decode
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SCREEN_WIDTH:  width_d  = pwdata[SCR_W-1:0];
        REG_SCREEN_HEIGHT: height_d = pwdata[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_SCREEN_WIDTH:  prdata = CFG_DW'(width_q);
      REG_SCREEN_HEIGHT: prdata = CFG_DW'(height_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.screen_width  = width_q;
  assign cfg_o.screen_height = height_q;

endmodule

`default_nettype wire

// ===== rtl/lwfs_clip.sv =====
// ----------------------------------------------------------------------------
// lwfs_clip
// Request register, reject check and clipping of the window to the screen.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lwfs_clip
  import lwfs_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 512,
  localparam int unsigned SideW = $clog2(MAX_SIDE + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output      logic             busy_o,
  input  wire req_t             req_i,
  input  wire cfg_t             cfg_i,
  input  wire logic             win_ready_i,
  output      logic             win_valid_o,
  output      win_t             win_o,
  output      logic [SideW-1:0] win_w_o,
  output      logic [SideW-1:0] win_h_o
);

  localparam logic [15:0] MaxSide16 = 16'(MAX_SIDE);

  logic             in_v_q, in_v_d;
  req_t             req_q;
  logic             win_v_q, win_v_d;
  win_t             win_q, win_d;
  logic [SideW-1:0] w_q, w_d, h_q, h_d;

  logic        accept, win_take, win_free, in_adv;
  logic [15:0] sw16, sh16;
  logic [16:0] xsum, ysum;
  logic        over_x, over_y, reject;
  logic [15:0] w_clip, h_clip;

  // Stage handshake
  assign win_take = win_v_q && win_ready_i;
  assign win_free = !win_v_q || win_take;
  assign in_adv   = in_v_q && win_free;
  assign busy_o   = in_v_q && !win_free;
  assign accept   = start_i && !busy_o;

  // Screen size, capped at the largest supported side
  assign sw16 = (16'(cfg_i.screen_width) > MaxSide16) ? MaxSide16 : 16'(cfg_i.screen_width);
  assign sh16 = (16'(cfg_i.screen_height) > MaxSide16) ? MaxSide16 : 16'(cfg_i.screen_height);

  // Reject off-screen origin or empty size
  assign reject = (req_q.origin_x >= sw16) || (req_q.origin_y >= sh16) ||
                  (req_q.rect_width == '0) || (req_q.rect_height == '0);

  // Far corner and clipped extent per axis
  assign xsum   = {1'b0, req_q.origin_x} + {1'b0, req_q.rect_width} - 17'd1;
  assign ysum   = {1'b0, req_q.origin_y} + {1'b0, req_q.rect_height} - 17'd1;
  assign over_x = xsum >= {1'b0, sw16};
  assign over_y = ysum >= {1'b0, sh16};
  assign w_clip = over_x ? (sw16 - req_q.origin_x) : req_q.rect_width;
  assign h_clip = over_y ? (sh16 - req_q.origin_y) : req_q.rect_height;

  always_comb begin
    win_d.x0    = req_q.origin_x;
    win_d.x1    = over_x ? (sw16 - 16'd1) : xsum[15:0];
    win_d.y0    = req_q.origin_y;
    win_d.y1    = over_y ? (sh16 - 16'd1) : ysum[15:0];
    win_d.color = req_q.fill_color;
    w_d         = w_clip[SideW-1:0];
    h_d         = h_clip[SideW-1:0];
  end

  // Valid flags
  always_comb begin
    in_v_d = in_v_q;
    if (accept) begin
      in_v_d = 1'b1;
    end else if (in_adv) begin
      in_v_d = 1'b0;
    end
    win_v_d = win_v_q;
    if (in_adv) begin
      win_v_d = !reject;
    end else if (win_take) begin
      win_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      win_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      win_v_q <= win_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (in_adv && !reject) begin
      win_q <= win_d;
      w_q   <= w_d;
      h_q   <= h_d;
    end
  end

  assign win_valid_o = win_v_q;
  assign win_o       = win_q;
  assign win_w_o     = w_q;
  assign win_h_o     = h_q;

  // Checks
  `ASSERT_IMPLIES(a_win_ordered, win_v_q, (win_q.x1 >= win_q.x0) && (win_q.y1 >= win_q.y0))
  `ASSERT_NEXT(a_win_hold, win_v_q && !win_take, win_v_q && $stable(win_q))
  `ASSERT_NEXT(a_req_hold, in_v_q && !win_free, in_v_q && $stable(req_q))

endmodule

`default_nettype wire

// ===== rtl/lwfs_serializer.sv =====
// ----------------------------------------------------------------------------
// lwfs_serializer
// Emits the twelve bus words of one clipped window, one word per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lwfs_serializer
  import lwfs_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 512,
  localparam int unsigned SideW = $clog2(MAX_SIDE + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             win_valid_i,
  output      logic             win_ready_o,
  input  wire win_t             win_i,
  input  wire logic [SideW-1:0] win_w_i,
  input  wire logic [SideW-1:0] win_h_i,
  output      logic             result_valid_o,
  output      res_t             result_o
);

  localparam int unsigned ProdW = 2 * SideW;
  localparam int unsigned CmpW  = (ProdW > COUNT_W) ? ProdW : COUNT_W;

  logic               active_q, active_d;
  word_sel_e          sel_q, sel_d;
  win_t               frame_q;
  logic [COUNT_W-1:0] count_q, count_d;

  logic             load;
  logic [ProdW-1:0] prod;

  assign win_ready_o = !active_q || (sel_q == WS_PIXELS);
  assign load        = win_valid_i && win_ready_o;

  // Pixel count, saturated to the repeat field
  assign prod    = ProdW'(win_w_i) * ProdW'(win_h_i);
  assign count_d = (CmpW'(prod) > CmpW'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(prod);

  // Next word select
  always_comb begin
    active_d = active_q;
    sel_d    = sel_q;
    if (load) begin
      active_d = 1'b1;
      sel_d    = WS_CMD_COL;
    end else if (active_q) begin
      unique case (sel_q)
        WS_CMD_COL:  sel_d = WS_XS_HI;
        WS_XS_HI:    sel_d = WS_XS_LO;
        WS_XS_LO:    sel_d = WS_XE_HI;
        WS_XE_HI:    sel_d = WS_XE_LO;
        WS_XE_LO:    sel_d = WS_CMD_PAGE;
        WS_CMD_PAGE: sel_d = WS_YS_HI;
        WS_YS_HI:    sel_d = WS_YS_LO;
        WS_YS_LO:    sel_d = WS_YE_HI;
        WS_YE_HI:    sel_d = WS_YE_LO;
        WS_YE_LO:    sel_d = WS_CMD_MEMW;
        WS_CMD_MEMW: sel_d = WS_PIXELS;
        WS_PIXELS:   active_d = 1'b0;
        default:     active_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      sel_q    <= WS_CMD_COL;
    end else begin
      active_q <= active_d;
      sel_q    <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= win_i;
      count_q <= count_d;
    end
  end

  // Word decode
  always_comb begin
    result_o.is_data      = 1'b1;
    result_o.repeat_count = COUNT_W'(1);
    result_o.last_word    = 1'b0;
    unique case (sel_q)
      WS_CMD_COL: begin
        result_o.is_data  = 1'b0;
        result_o.bus_word = {8'h00, CMD_COLUMN_ADDR};
      end
      WS_XS_HI:    result_o.bus_word = {8'h00, frame_q.x0[15:8]};
      WS_XS_LO:    result_o.bus_word = {8'h00, frame_q.x0[7:0]};
      WS_XE_HI:    result_o.bus_word = {8'h00, frame_q.x1[15:8]};
      WS_XE_LO:    result_o.bus_word = {8'h00, frame_q.x1[7:0]};
      WS_CMD_PAGE: begin
        result_o.is_data  = 1'b0;
        result_o.bus_word = {8'h00, CMD_PAGE_ADDR};
      end
      WS_YS_HI:    result_o.bus_word = {8'h00, frame_q.y0[15:8]};
      WS_YS_LO:    result_o.bus_word = {8'h00, frame_q.y0[7:0]};
      WS_YE_HI:    result_o.bus_word = {8'h00, frame_q.y1[15:8]};
      WS_YE_LO:    result_o.bus_word = {8'h00, frame_q.y1[7:0]};
      WS_CMD_MEMW: begin
        result_o.is_data  = 1'b0;
        result_o.bus_word = {8'h00, CMD_MEMORY_WRITE};
      end
      WS_PIXELS: begin
        result_o.bus_word     = frame_q.color;
        result_o.repeat_count = count_q;
        result_o.last_word    = 1'b1;
      end
      default:     result_o.bus_word = '0;
    endcase
  end

  assign result_valid_o = active_q;

  // Checks
  `ASSERT_NEXT(a_burst_contiguous, result_valid_o && !result_o.last_word, result_valid_o)
  `ASSERT_NEXT(a_idle_after_last, result_valid_o && result_o.last_word && !load, !result_valid_o)
  `ASSERT_IMPLIES(a_count_nonzero, result_valid_o, result_o.repeat_count != '0)
  `ASSERT_IMPLIES(a_cmd_high_zero, result_valid_o && !result_o.is_data, result_o.bus_word[15:8] == 8'h00)

endmodule

`default_nettype wire

// ===== rtl/lcd_window_fill_sequencer.sv =====
// ----------------------------------------------------------------------------
// lcd_window_fill_sequencer
// Turns a rectangle fill request into the word sequence of a parallel
// display bus: column and page address setup, memory write, pixel burst.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request that
// is not rejected yields twelve words on result_o, one per cycle with
// result_valid_o high and no gaps; the receiver cannot stall, so it must take
// a word in every cycle that result_valid_o is high. The word serializer
// sets the rate: it is occupied by each window until its last word, and busy
// rises only when the request and window registers are both full behind it.
// Rejected requests (off-screen origin, zero size) leave the request register
// at the next edge at which the window register is free and produce no words.
// A request reaches result_o through the request register, the window
// register and the serializer registers. The user must write the screen size
// registers through the APB port only while idle; the block does not check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lcd_window_fill_sequencer
  import lwfs_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 512
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output      logic [CFG_DW-1:0] prdata,
  output      logic              pready,
  input  wire logic              start,
  output      logic              busy,
  input  wire req_t              req_i,
  output      logic              result_valid_o,
  output      res_t              result_o
);

  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);

  cfg_t             cfg;
  logic             win_valid, win_ready;
  win_t             win;
  logic [SideW-1:0] win_w, win_h;

  // Screen size registers
  lwfs_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Request register and clipping
  lwfs_clip #(
    .MAX_SIDE (MAX_SIDE)
  ) u_clip (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .win_ready_i (win_ready),
    .win_valid_o (win_valid),
    .win_o       (win),
    .win_w_o     (win_w),
    .win_h_o     (win_h)
  );

  // Word serializer
  lwfs_serializer #(
    .MAX_SIDE (MAX_SIDE)
  ) u_ser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_valid_i    (win_valid),
    .win_ready_o    (win_ready),
    .win_i          (win),
    .win_w_i        (win_w),
    .win_h_i        (win_h),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

`default_nettype wire
